/* rtl/qrsfc_pkg.sv */
// ----------------------------------------------------------------------------
// QRS filter chain package
// Field widths, filter tap positions and reset values shared by the
// filter chain and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package qrsfc_pkg;

  // port field widths
  localparam int SAMPLE_W = 12;
  localparam int BP_W     = 14;
  localparam int SQ_W     = 24;
  localparam int LIMIT_W  = 30;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd4096;

  // low-pass section: y = 2y1 - y2 + x - 2x(n-6) + x(n-12)
  localparam int LP_DEPTH = 12;
  localparam int LP_TAP   = 6;
  localparam int LP_Y_W   = 20;   // stored past outputs
  localparam int LP_ACC_W = 23;   // signed working width
  localparam int LP_OUT_W = 13;   // y >> 5

  // high-pass section: x(n-16) - (sum of last 32) >> 5
  localparam int HP_DEPTH = 32;
  localparam int HP_TAP   = 16;
  localparam int HP_SUM_W = 19;

  // derivative and window scaling
  localparam int DER_W    = 17;
  localparam int DER_SHR  = 3;
  localparam int SUM_SHR  = 5;

endpackage : qrsfc_pkg

`default_nettype wire

/* rtl/qrs_filter_chain_unit.sv */
// ----------------------------------------------------------------------------
// QRS filter chain unit
// Low-pass, high-pass, five-point derivative, squaring and moving window
// integration of a 12-bit ECG sample stream, one result per sample.
// ----------------------------------------------------------------------------
// Pipeline: five registered stages, output included; an accepted sample's
//   result reaches the output register after passing through each in turn.
// Throughput: one sample per cycle; each stage advances whenever the stage
//   ahead is empty or moving, so a full output only stalls what is behind it.
// Reset: synchronous, active low; clears all delay lines, sums and valid bits
//   at once, limit returns to 4096. The window memory is not swept: a fill
//   count treats entries not yet written as zero.
`default_nettype none

module qrs_filter_chain_unit #(
  parameter int WINDOW_LENGTH = 72
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [qrsfc_pkg::SAMPLE_W-1:0]      in_ecg_sample,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qrsfc_pkg::BP_W-1:0]   out_bandpass_value,
  output logic [qrsfc_pkg::SQ_W-1:0]          out_slope_squared,
  output logic [qrsfc_pkg::LIMIT_W-1:0]       out_integral_value,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qrsfc_pkg::LIMIT_W-1:0]       cfg_integral_limit
);

  import qrsfc_pkg::*;

  localparam int PTR_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W   = SQ_W + $clog2(WINDOW_LENGTH);
  localparam int INTEG_W = SUM_W - SUM_SHR;
  localparam int CMP_W   = (INTEG_W > LIMIT_W) ? INTEG_W : LIMIT_W;
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(WINDOW_LENGTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(WINDOW_LENGTH);

  // --------------------------------------------------------------------------
  // stage handshake
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic acc, adv1, adv2, adv3, adv4;

  assign adv4     = v4_r & (~out_valid_r | out_ready);
  assign adv3     = v3_r & (~v4_r | adv4);
  assign adv2     = v2_r & (~v3_r | adv3);
  assign adv1     = v1_r & (~v2_r | adv2);
  assign in_ready = ~v1_r | adv1;
  assign acc      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= acc  | (v1_r & ~adv1);
      v2_r        <= adv1 | (v2_r & ~adv2);
      v3_r        <= adv2 | (v3_r & ~adv3);
      v4_r        <= adv3 | (v4_r & ~adv4);
      out_valid_r <= adv4 | (out_valid_r & ~out_ready);
    end
  end

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_integral_limit;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: low-pass, computed on the accepted beat
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]        lp_dly_r [LP_DEPTH];
  logic [LP_Y_W-1:0]          y1_r, y2_r;
  logic signed [LP_ACC_W-1:0] y_full;
  logic [LP_OUT_W-1:0]        lp_val;
  logic [LP_OUT_W-1:0]        s1_lp_r;

  assign y_full = $signed(LP_ACC_W'(y1_r) << 1) - $signed(LP_ACC_W'(y2_r))
                + $signed(LP_ACC_W'(in_ecg_sample))
                - $signed(LP_ACC_W'(lp_dly_r[LP_TAP-1]) << 1)
                + $signed(LP_ACC_W'(lp_dly_r[LP_DEPTH-1]));

  // negative outputs clip to zero
  assign lp_val = y_full[LP_ACC_W-1] ? '0 : LP_OUT_W'(y_full >>> SUM_SHR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LP_DEPTH; i++) lp_dly_r[i] <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (acc) begin
      lp_dly_r[0] <= in_ecg_sample;
      for (int i = 1; i < LP_DEPTH; i++) lp_dly_r[i] <= lp_dly_r[i-1];
      y2_r <= y1_r;
      y1_r <= y_full[LP_Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_lp_r <= lp_val;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: high-pass
  // --------------------------------------------------------------------------
  logic [LP_OUT_W-1:0]    hp_dly_r [HP_DEPTH];
  logic [HP_SUM_W-1:0]    hp_sum_r, hp_sum_nxt;
  logic signed [BP_W:0]   bp_full;
  logic signed [BP_W-1:0] s2_bp_r;

  assign hp_sum_nxt = hp_sum_r + HP_SUM_W'(s1_lp_r) - HP_SUM_W'(hp_dly_r[HP_DEPTH-1]);
  assign bp_full    = $signed({2'b00, hp_dly_r[HP_TAP-1]})
                    - $signed({1'b0, hp_sum_nxt[HP_SUM_W-1:SUM_SHR]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HP_DEPTH; i++) hp_dly_r[i] <= '0;
      hp_sum_r <= '0;
    end else if (adv1) begin
      hp_dly_r[0] <= s1_lp_r;
      for (int i = 1; i < HP_DEPTH; i++) hp_dly_r[i] <= hp_dly_r[i-1];
      hp_sum_r <= hp_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_bp_r <= bp_full[BP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: five-point derivative, floor shift by 3
  // --------------------------------------------------------------------------
  logic signed [BP_W-1:0]  dd_r [4];   // dd_r[k]: band-pass value k+1 beats ago
  logic signed [DER_W-1:0] d_full;
  logic signed [DER_W-1:0] d_shr;
  logic signed [BP_W-1:0]  s3_bp_r, s3_d_r;

  assign d_full = (DER_W'(s2_bp_r) <<< 1) + DER_W'(dd_r[0])
                - DER_W'(dd_r[2]) - (DER_W'(dd_r[3]) <<< 1);
  assign d_shr  = d_full >>> DER_SHR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) dd_r[i] <= '0;
    end else if (adv2) begin
      dd_r[0] <= s2_bp_r;
      for (int i = 1; i < 4; i++) dd_r[i] <= dd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_bp_r <= s2_bp_r;
      s3_d_r  <= d_shr[BP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squaring
  // --------------------------------------------------------------------------
  logic signed [2*BP_W-1:0] sq_full;
  logic signed [BP_W-1:0]   s4_bp_r;
  logic [SQ_W-1:0]          s4_sq_r;

  assign sq_full = s3_d_r * s3_d_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s4_bp_r <= s3_bp_r;
      s4_sq_r <= sq_full[SQ_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: moving window integral into the output register
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]        win_mem [WINDOW_LENGTH];
  logic [SQ_W-1:0]        win_rd_r;
  logic                   byp_r;
  logic [PTR_W-1:0]       ptr_r, wr_ptr, next_ptr, rd_addr;
  logic [FILL_W-1:0]      fill_r;
  logic [SUM_W-1:0]       win_sum_r, win_sum_nxt;
  logic [SQ_W-1:0]        old_sq;
  logic [CMP_W-1:0]       integ, lim_ext, integ_clamp;
  logic signed [BP_W-1:0] out_bp_r;
  logic [SQ_W-1:0]        out_sq_r;
  logic [LIMIT_W-1:0]     out_integ_r;

  assign wr_ptr   = (ptr_r == LAST_PTR) ? '0 : ptr_r + 1'b1;
  assign next_ptr = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
  // prefetch the entry the next beat will retire
  assign rd_addr  = adv4 ? next_ptr : wr_ptr;

  // entries not yet written count as zero; a same-address prefetch is stale,
  // so take the square just stored instead
  assign old_sq = (fill_r != FULL_CNT) ? '0 : (byp_r ? out_sq_r : win_rd_r);

  assign win_sum_nxt = win_sum_r - SUM_W'(old_sq) + SUM_W'(s4_sq_r);
  assign integ       = CMP_W'(win_sum_nxt >> SUM_SHR);
  assign lim_ext     = CMP_W'(limit_r);
  assign integ_clamp = (integ > lim_ext) ? lim_ext : integ;

  always_ff @(posedge clk) begin
    if (adv4) begin
      win_mem[wr_ptr] <= s4_sq_r;
    end
    win_rd_r <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      fill_r    <= '0;
      win_sum_r <= '0;
      byp_r     <= 1'b0;
    end else begin
      byp_r <= adv4 && (rd_addr == wr_ptr);
      if (adv4) begin
        ptr_r     <= wr_ptr;
        win_sum_r <= win_sum_nxt;
        if (fill_r != FULL_CNT) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_bp_r    <= s4_bp_r;
      out_sq_r    <= s4_sq_r;
      out_integ_r <= integ_clamp[LIMIT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bandpass_value = out_bp_r;
  assign out_slope_squared  = out_sq_r;
  assign out_integral_value = out_integ_r;

endmodule : qrs_filter_chain_unit

`default_nettype wire

/* rtl/qrsfc_checker.sv */
// ----------------------------------------------------------------------------
// QRS filter chain checker
// Port-level checks on the filter chain's result channel and input ready.
// ----------------------------------------------------------------------------
`default_nettype none

module qrsfc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qrsfc_pkg::BP_W-1:0]   out_bandpass_value,
  input logic [qrsfc_pkg::SQ_W-1:0]          out_slope_squared,
  input logic [qrsfc_pkg::LIMIT_W-1:0]       out_integral_value
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output register empty every stage drains, so a beat is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bandpass_value)
      && $stable(out_slope_squared) && $stable(out_integral_value))
    else $error("result beat changed while stalled");

endmodule : qrsfc_checker

bind qrs_filter_chain_unit qrsfc_checker u_qrsfc_checker (.*);

`default_nettype wire
